// ===== hdl/csp_pkg.sv =====
// csp_pkg: shared types, constants and the named colour table for the colour string parser
// depends on nothing; imported by every module of the parser
`timescale 1ns / 1ps

package csp_pkg;

  localparam int TABLE_ENTRIES   = 38;
  localparam int MAX_CHARS       = 12;
  localparam int TRANSPARENT_IDX = 37;
  localparam int NAME_CHARS      = 11;
  localparam int POS_W           = 4;
  localparam int NIBBLE_W        = 24;

  localparam logic [7:0] HASH_CHAR   = 8'h23;
  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;
  localparam logic [7:0] ALPHA_CLEAR  = 8'd0;
  localparam logic [POS_W-1:0] HEX6_LEN = POS_W'(7);
  localparam logic [POS_W-1:0] HEX3_LEN = POS_W'(4);

  // one named colour: text right-aligned, last character in the low byte
  typedef struct packed {
    logic [8*NAME_CHARS-1:0] txt;
    logic [POS_W-1:0]        len;
    logic [7:0]              r;
    logic [7:0]              g;
    logic [7:0]              b;
  } color_entry_t;

  localparam color_entry_t COLOR_TABLE [TABLE_ENTRIES] = '{
    '{"black",       4'd5,  8'd0,   8'd0,   8'd0  },
    '{"white",       4'd5,  8'd255, 8'd255, 8'd255},
    '{"red",         4'd3,  8'd255, 8'd0,   8'd0  },
    '{"green",       4'd5,  8'd0,   8'd128, 8'd0  },
    '{"blue",        4'd4,  8'd0,   8'd0,   8'd255},
    '{"yellow",      4'd6,  8'd255, 8'd255, 8'd0  },
    '{"cyan",        4'd4,  8'd0,   8'd255, 8'd255},
    '{"magenta",     4'd7,  8'd255, 8'd0,   8'd255},
    '{"darkblue",    4'd8,  8'd0,   8'd0,   8'd139},
    '{"darkgreen",   4'd9,  8'd0,   8'd100, 8'd0  },
    '{"darkred",     4'd7,  8'd139, 8'd0,   8'd0  },
    '{"darkcyan",    4'd8,  8'd0,   8'd139, 8'd139},
    '{"darkmagenta", 4'd11, 8'd139, 8'd0,   8'd139},
    '{"darkyellow",  4'd10, 8'd139, 8'd139, 8'd0  },
    '{"gray",        4'd4,  8'd128, 8'd128, 8'd128},
    '{"grey",        4'd4,  8'd128, 8'd128, 8'd128},
    '{"lightgray",   4'd9,  8'd211, 8'd211, 8'd211},
    '{"lightgrey",   4'd9,  8'd211, 8'd211, 8'd211},
    '{"darkgray",    4'd8,  8'd169, 8'd169, 8'd169},
    '{"darkgrey",    4'd8,  8'd169, 8'd169, 8'd169},
    '{"silver",      4'd6,  8'd192, 8'd192, 8'd192},
    '{"orange",      4'd6,  8'd255, 8'd165, 8'd0  },
    '{"pink",        4'd4,  8'd255, 8'd192, 8'd203},
    '{"purple",      4'd6,  8'd128, 8'd0,   8'd128},
    '{"brown",       4'd5,  8'd139, 8'd69,  8'd19 },
    '{"lime",        4'd4,  8'd0,   8'd255, 8'd0  },
    '{"navy",        4'd4,  8'd0,   8'd0,   8'd128},
    '{"teal",        4'd4,  8'd0,   8'd128, 8'd128},
    '{"maroon",      4'd6,  8'd128, 8'd0,   8'd0  },
    '{"olive",       4'd5,  8'd128, 8'd128, 8'd0  },
    '{"aqua",        4'd4,  8'd0,   8'd255, 8'd255},
    '{"fuchsia",     4'd7,  8'd255, 8'd0,   8'd255},
    '{"coral",       4'd5,  8'd255, 8'd127, 8'd80 },
    '{"salmon",      4'd6,  8'd250, 8'd128, 8'd114},
    '{"gold",        4'd4,  8'd255, 8'd215, 8'd0  },
    '{"indigo",      4'd6,  8'd75,  8'd0,   8'd130},
    '{"violet",      4'd6,  8'd238, 8'd130, 8'd238},
    '{"transparent", 4'd11, 8'd0,   8'd0,   8'd0  }
  };

  // parse state carried from one character to the next
  typedef struct packed {
    logic [POS_W-1:0]         pos;
    logic                     hex_mode;
    logic [NIBBLE_W-1:0]      nibbles;
    logic                     hex_invalid;
    logic [TABLE_ENTRIES-1:0] mask;
    logic                     too_long;
  } parse_state_t;

  // one finished result
  typedef struct packed {
    logic       ok;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } color_result_t;

  // character of a table entry at a given position, zero past its end
  function automatic logic [7:0] entry_char(input int idx, input logic [POS_W-1:0] p);
    int sh;
    sh = 8 * (int'(COLOR_TABLE[idx].len) - 1 - int'(p));
    if (sh < 0) begin
      return 8'd0;
    end
    return COLOR_TABLE[idx].txt[sh +: 8];
  endfunction

endpackage

// ===== hdl/csp_parse.sv =====
// csp_parse: per-character parse state registers and their next-state logic
// depends on csp_pkg
`timescale 1ns / 1ps

module csp_parse
  import csp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         step,
  input  logic [7:0]   char_code,
  input  logic         is_last,
  output parse_state_t state,
  output parse_state_t state_next
);

  logic [7:0]               low;
  logic                     digit_ok;
  logic [3:0]               digit;
  logic [TABLE_ENTRIES-1:0] keep;

  parse_state_t reset_state;
  assign reset_state = '{pos: '0, hex_mode: 1'b0, nibbles: '0, hex_invalid: 1'b0,
                         mask: '1, too_long: 1'b0};

  // fold upper case letters to lower case
  always_comb begin
    if (char_code >= "A" && char_code <= "Z") begin
      low = char_code + 8'd32;
    end else begin
      low = char_code;
    end
  end

  // hex digit decode, either case
  always_comb begin
    digit_ok = 1'b1;
    digit    = 4'd0;
    if (char_code >= "0" && char_code <= "9") begin
      digit = 4'(char_code - "0");
    end else if (char_code >= "a" && char_code <= "f") begin
      digit = 4'(char_code - "a" + 8'd10);
    end else if (char_code >= "A" && char_code <= "F") begin
      digit = 4'(char_code - "A" + 8'd10);
    end else begin
      digit_ok = 1'b0;
    end
  end

  // one comparator per table entry
  always_comb begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      keep[i] = (state.pos < COLOR_TABLE[i].len) && (entry_char(i, state.pos) == low);
    end
  end

  // next state for the character in hand
  always_comb begin
    state_next = state;
    if (state.pos >= POS_W'(MAX_CHARS)) begin
      state_next.too_long = 1'b1;
    end else begin
      if (state.pos == '0 && char_code == HASH_CHAR) begin
        state_next.hex_mode = 1'b1;
      end
      if (state.pos != '0 && state.hex_mode) begin
        if (!digit_ok) begin
          state_next.hex_invalid = 1'b1;
        end else begin
          state_next.nibbles = {state.nibbles[NIBBLE_W-5:0], digit};
        end
      end
      state_next.mask = state.mask & keep;
      state_next.pos  = state.pos + POS_W'(1);
    end
  end

  // state returns to reset after each last character
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= reset_state;
    end else if (step) begin
      if (is_last) begin
        state <= reset_state;
      end else begin
        state <= state_next;
      end
    end
  end

endmodule

// ===== hdl/csp_resolve.sv =====
// csp_resolve: turns the final parse state into a colour result
// depends on csp_pkg
`timescale 1ns / 1ps

module csp_resolve
  import csp_pkg::*;
(
  input  parse_state_t  fin,
  output color_result_t result
);

  logic [TABLE_ENTRIES-1:0] hit;
  logic [TABLE_ENTRIES-1:0] first_hit;
  color_result_t            named;
  logic [3:0]               d_r, d_g, d_b;

  // entries still in the running whose length matches exactly
  always_comb begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      hit[i] = fin.mask[i] && (COLOR_TABLE[i].len == fin.pos);
    end
  end

  // lowest matching entry wins
  assign first_hit = hit & (~hit + TABLE_ENTRIES'(1));

  always_comb begin
    named = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (first_hit[i]) begin
        named.ok    = 1'b1;
        named.red   = named.red   | COLOR_TABLE[i].r;
        named.green = named.green | COLOR_TABLE[i].g;
        named.blue  = named.blue  | COLOR_TABLE[i].b;
        named.alpha = named.alpha | ((i == TRANSPARENT_IDX) ? ALPHA_CLEAR : ALPHA_OPAQUE);
      end
    end
  end

  // short form digits, each times 17 is the digit doubled
  assign d_r = fin.nibbles[11:8];
  assign d_g = fin.nibbles[7:4];
  assign d_b = fin.nibbles[3:0];

  // pick hex or named result, zero on failure
  always_comb begin
    result = '0;
    if (!fin.too_long) begin
      if (fin.hex_mode) begin
        if (!fin.hex_invalid && fin.pos == HEX6_LEN) begin
          result = '{ok: 1'b1, red: fin.nibbles[23:16], green: fin.nibbles[15:8],
                     blue: fin.nibbles[7:0], alpha: ALPHA_OPAQUE};
        end else if (!fin.hex_invalid && fin.pos == HEX3_LEN) begin
          result = '{ok: 1'b1, red: {d_r, d_r}, green: {d_g, d_g},
                     blue: {d_b, d_b}, alpha: ALPHA_OPAQUE};
        end
      end else begin
        result = named;
      end
    end
  end

endmodule

// ===== hdl/color_string_parser_core.sv =====
// color_string_parser_core: top level of the colour string parser, stream ports and registers
// depends on csp_pkg, csp_parse and csp_resolve
`timescale 1ns / 1ps

// Parses a colour string sent one character per request, the last character marked by
// s_tlast. Strings starting with '#' take 3 or 6 hex digits of either case; anything else
// is matched, case folded, against a table of 38 named colours, "transparent" giving alpha
// 0. Exactly one result follows each last character: m_tuser is 1 on success, and on
// failure all channels are 0. Strings longer than 12 characters fail. One character is
// taken every cycle while the input is not stalled; a result is presented once its last
// character has passed from the input register into the result register. While a result
// waits unread, further characters of the next string are still taken; the next last
// character is held in the input register and stalls the input until the waiting result is
// read.
module color_string_parser_core
  import csp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_code
  input  logic        s_tlast,   // is_last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha
  output logic        m_tuser    // ok
);

  logic          in_valid;
  logic [7:0]    in_char;
  logic          in_last;
  logic          out_free;
  logic          advance;
  parse_state_t  state;
  parse_state_t  state_next;
  color_result_t result;

  // character in the input register moves on unless its result has nowhere to go
  assign out_free = !m_tvalid || m_tready;
  assign advance  = in_valid && (!in_last || out_free);
  assign s_tready = !in_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_char <= s_tdata;
      in_last <= s_tlast;
    end
  end

  csp_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .char_code  (in_char),
    .is_last    (in_last),
    .state      (state),
    .state_next (state_next)
  );

  csp_resolve u_resolve (
    .fin    (state_next),
    .result (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && in_last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last) begin
      m_tuser <= result.ok;
      m_tdata <= {result.alpha, result.blue, result.green, result.red};
    end
  end

`ifndef NO_ASSERTIONS
  // a failed result carries zero channels
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata == '0))
    else $error("failed result with nonzero channels");

  // position saturates at the character limit
  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    state.pos <= POS_W'(MAX_CHARS))
    else $error("character position beyond limit");

  // parse state is back at reset after a last character
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (advance && in_last) |=> (state.pos == '0 && state.mask == '1 && !state.hex_mode
                              && !state.too_long))
    else $error("parse state not cleared after last character");

  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !(advance && in_last))
    else $error("result overwritten while waiting");
`endif

endmodule
